// ===== rtl/thermadc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, band-edge table and helper for the thermistor linearizer.
// No dependencies.
package thermadc_pkg;

  // Converter and fixed-point formats
  localparam int ADC_BITS      = 12;
  localparam int SAMPLE_W      = 16;                     // input tdata width
  localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};
  localparam int FRAC_BITS     = 16;                     // ratio Q16
  localparam int RATIO_W       = 20;                     // saturated ratio, max 8.0
  localparam int RATIO_QB      = RATIO_W + 1;            // extra top bit flags overflow
  localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(8 << FRAC_BITS);
  localparam int RATIO_REM_W   = ADC_BITS + RATIO_QB;

  // Band table
  localparam int TABLE_ENTRIES = 10;
  localparam int SEG_W         = $clog2(TABLE_ENTRIES);
  localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(TABLE_ENTRIES - 2);
  localparam logic [RATIO_W-1:0] BAND_EDGE [TABLE_ENTRIES] = '{
    20'd277348, 20'd213975, 20'd166396, 20'd130417, 20'd102957,
    20'd81854,  20'd65536,  20'd52802,  20'd42802,  20'd34911
  };
  localparam int DEN_W         = 16;                     // widest segment span fits

  // Interpolation
  localparam int TEMP_W        = 16;                     // signed Q8.8
  localparam logic [TEMP_W-1:0] STEP_Q88 = TEMP_W'(1280); // 5.0 C
  localparam int PROD_W        = RATIO_W + 11;           // num * 1280 + den/2
  localparam int FRAC_QB       = 13;                     // largest fraction is 6943

  // Configuration
  localparam int CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;
  localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST  = 16'sd7680;
  localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 16'sd12800;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              sensor_ok;
    logic              ratio_above_table;
    logic              adc_full_scale;
  } result_t;

  // Span of segment seg (edge[seg] - edge[seg+1])
  function automatic logic [DEN_W-1:0] seg_den(input logic [SEG_W-1:0] seg);
    logic [SEG_W-1:0]   nxt;
    logic [RATIO_W-1:0] diff;
    nxt  = seg + SEG_W'(1);
    diff = BAND_EDGE[seg] - BAND_EDGE[nxt];
    return DEN_W'(diff);
  endfunction

endpackage

// ===== rtl/thermistor_adc_to_temperature_top.sv =====
`timescale 1ns / 1ps
// Throughput: one transfer per cycle while the skid entry is free; the 21-stage ratio
// divider and the 13-stage fraction divider, one quotient bit per stage, set the depth.
// A registered output plus one skid entry decouple the sides; s_axis_tready is registered.
// Reset (rst_ni, async low) clears all stage valid bits and loads the limit registers.
// Depends on thermadc_pkg.
module thermistor_adc_to_temperature_top
  import thermadc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [11:0] adc_sample, rest zero
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TEMP_W-1:0]    m_axis_tdata,   // [15:0] temperature (signed Q8.8)
  output logic [2:0]           m_axis_tuser,   // [0] sensor_ok [1] ratio_above_table
                                               // [2] adc_full_scale
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TEMP_W-1:0]    cfg_wdata_i
);

  // -------------------------------------------------------------------------
  // Pipeline enable: the whole pipe moves while the skid entry is free.
  // -------------------------------------------------------------------------
  logic skid_vld_q;
  logic en;
  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  // -------------------------------------------------------------------------
  // Limit registers
  // -------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] low_lim_q, high_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_lim_q  <= LOW_LIMIT_RST;
      high_lim_q <= HIGH_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW_LIMIT:  low_lim_q  <= $signed(cfg_wdata_i);
        REG_HIGH_LIMIT: high_lim_q <= $signed(cfg_wdata_i);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Input stage: numerator s*2^16 + d/2 and divisor d = FULL - s.
  // Stage 0 of the ratio divider arrays.
  // -------------------------------------------------------------------------
  logic [ADC_BITS-1:0]    smp;
  logic [ADC_BITS-1:0]    div_d;
  logic [RATIO_REM_W-1:0] num_d;

  assign smp   = s_axis_tdata[ADC_BITS-1:0];
  assign div_d = ADC_FULL - smp;
  assign num_d = (RATIO_REM_W'(smp) << FRAC_BITS) + RATIO_REM_W'(div_d >> 1);

  logic                   rq_vld_q  [RATIO_QB+1];
  logic [RATIO_REM_W-1:0] rq_rem_q  [RATIO_QB+1];
  logic [ADC_BITS-1:0]    rq_d_q    [RATIO_QB+1];
  logic [RATIO_QB-1:0]    rq_quo_q  [RATIO_QB+1];
  logic                   rq_fail_q [RATIO_QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_vld_q[0] <= 1'b0;
    end else if (en) begin
      rq_vld_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq_rem_q[0]  <= num_d;
      rq_d_q[0]    <= div_d;
      rq_quo_q[0]  <= '0;
      rq_fail_q[0] <= (smp == ADC_FULL);
    end
  end

  // -------------------------------------------------------------------------
  // Ratio divider: restoring, one quotient bit per stage, MSB first.
  // The top bit only marks a quotient of 2^20 or more, which saturates anyway.
  // -------------------------------------------------------------------------
  for (genvar j = 0; j < RATIO_QB; j++) begin : g_ratio_div
    localparam int B = RATIO_QB - 1 - j;
    logic [RATIO_REM_W-1:0] dsh;
    logic                   fit;

    assign dsh = RATIO_REM_W'(rq_d_q[j]) << B;
    assign fit = (rq_rem_q[j] >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rq_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        rq_vld_q[j+1] <= rq_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rq_rem_q[j+1]  <= fit ? (rq_rem_q[j] - dsh) : rq_rem_q[j];
        rq_quo_q[j+1]  <= {rq_quo_q[j][RATIO_QB-2:0], fit};
        rq_d_q[j+1]    <= rq_d_q[j];
        rq_fail_q[j+1] <= rq_fail_q[j];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Saturate the ratio at 8.0
  // -------------------------------------------------------------------------
  logic               sat_vld_q, sat_fail_q;
  logic [RATIO_W-1:0] sat_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_vld_q <= 1'b0;
    end else if (en) begin
      sat_vld_q <= rq_vld_q[RATIO_QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_ratio_q <= (rq_quo_q[RATIO_QB] > RATIO_QB'(RATIO_MAX)) ?
                     RATIO_MAX : rq_quo_q[RATIO_QB][RATIO_W-1:0];
      sat_fail_q  <= rq_fail_q[RATIO_QB];
    end
  end

  // -------------------------------------------------------------------------
  // Compare against every band edge in parallel
  // -------------------------------------------------------------------------
  logic                     cmp_vld_q, cmp_fail_q;
  logic [RATIO_W-1:0]       cmp_ratio_q;
  logic [TABLE_ENTRIES-1:0] cmp_ge_q;
  logic [TABLE_ENTRIES-1:0] ge_d;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      ge_d[i] = (BAND_EDGE[i] >= sat_ratio_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else if (en) begin
      cmp_vld_q <= sat_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmp_ratio_q <= sat_ratio_q;
      cmp_fail_q  <= sat_fail_q;
      cmp_ge_q    <= ge_d;
    end
  end

  // -------------------------------------------------------------------------
  // Pick the segment: highest matching edge, last one extrapolates.
  // -------------------------------------------------------------------------
  logic [SEG_W-1:0] found;
  logic [SEG_W-1:0] seg_d;

  always_comb begin
    found = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmp_ge_q[i]) begin
        found = SEG_W'(i);
      end
    end
    seg_d = (found > LAST_SEG) ? LAST_SEG : found;
  end

  logic               seg_vld_q, seg_fail_q, seg_above_q;
  logic [SEG_W-1:0]   seg_q;
  logic [RATIO_W-1:0] seg_num_q;
  logic [DEN_W-1:0]   seg_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q <= 1'b0;
    end else if (en) begin
      seg_vld_q <= cmp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seg_q       <= seg_d;
      seg_num_q   <= BAND_EDGE[seg_d] - cmp_ratio_q;
      seg_den_q   <= seg_den(seg_d);
      seg_above_q <= ~cmp_ge_q[0];
      seg_fail_q  <= cmp_fail_q;
    end
  end

  // -------------------------------------------------------------------------
  // Scale: 1280 * num + den/2 feeds the fraction divider (stage 0)
  // -------------------------------------------------------------------------
  localparam int FD_N = FRAC_QB + 1;

  logic              fd_vld_q   [FD_N];
  logic [PROD_W-1:0] fd_rem_q   [FD_N];
  logic [DEN_W-1:0]  fd_den_q   [FD_N];
  logic [FRAC_QB-1:0] fd_quo_q  [FD_N];
  logic [SEG_W-1:0]  fd_seg_q   [FD_N];
  logic              fd_above_q [FD_N];
  logic              fd_fail_q  [FD_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_vld_q[0] <= 1'b0;
    end else if (en) begin
      fd_vld_q[0] <= seg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_rem_q[0]   <= (PROD_W'(seg_num_q) * PROD_W'(STEP_Q88)) +
                       PROD_W'(seg_den_q >> 1);
      fd_den_q[0]   <= seg_den_q;
      fd_quo_q[0]   <= '0;
      fd_seg_q[0]   <= seg_q;
      fd_above_q[0] <= seg_above_q;
      fd_fail_q[0]  <= seg_fail_q;
    end
  end

  // Fraction divider, rounded quotient of the scaled offset over the span
  for (genvar j = 0; j < FRAC_QB; j++) begin : g_frac_div
    localparam int B = FRAC_QB - 1 - j;
    logic [PROD_W-1:0] dsh;
    logic              fit;

    assign dsh = PROD_W'(fd_den_q[j]) << B;
    assign fit = (fd_rem_q[j] >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fd_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        fd_vld_q[j+1] <= fd_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fd_rem_q[j+1]   <= fit ? (fd_rem_q[j] - dsh) : fd_rem_q[j];
        fd_quo_q[j+1]   <= {fd_quo_q[j][FRAC_QB-2:0], fit};
        fd_den_q[j+1]   <= fd_den_q[j];
        fd_seg_q[j+1]   <= fd_seg_q[j];
        fd_above_q[j+1] <= fd_above_q[j];
        fd_fail_q[j+1]  <= fd_fail_q[j];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Temperature = (seg - 1) * 5.0 C + fraction; zero for no band or failure.
  // Range stays well inside 16 bits, so modular math is exact.
  // -------------------------------------------------------------------------
  logic              tmp_vld_q, tmp_fail_q, tmp_above_q;
  logic [TEMP_W-1:0] tmp_temp_q;
  logic [TEMP_W-1:0] temp_d;

  assign temp_d = TEMP_W'(fd_seg_q[FRAC_QB]) * STEP_Q88 - STEP_Q88 +
                  TEMP_W'(fd_quo_q[FRAC_QB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmp_vld_q <= 1'b0;
    end else if (en) begin
      tmp_vld_q <= fd_vld_q[FRAC_QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tmp_temp_q  <= (fd_above_q[FRAC_QB] || fd_fail_q[FRAC_QB]) ? '0 : temp_d;
      tmp_above_q <= fd_above_q[FRAC_QB] & ~fd_fail_q[FRAC_QB];
      tmp_fail_q  <= fd_fail_q[FRAC_QB];
    end
  end

  // -------------------------------------------------------------------------
  // Limit check and output register with one skid entry
  // -------------------------------------------------------------------------
  result_t res_d, out_q, skid_q;
  logic    out_vld_q;
  logic    out_take;

  always_comb begin
    res_d.temperature       = tmp_temp_q;
    res_d.sensor_ok         = ~tmp_fail_q &&
                              ($signed(tmp_temp_q) >= low_lim_q) &&
                              ($signed(tmp_temp_q) <= high_lim_q);
    res_d.ratio_above_table = tmp_above_q;
    res_d.adc_full_scale    = tmp_fail_q;
  end

  assign out_take = out_vld_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // pipe is frozen; drain the skid entry into the output register
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (tmp_vld_q) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (tmp_vld_q) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.temperature;
  assign m_axis_tuser  = {out_q.adc_full_scale, out_q.ratio_above_table, out_q.sensor_ok};

`ifndef ASSERT_OFF
  // A held skid entry always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while output register empty");

  // Converter failure gives zero temperature, not ok, no table flag.
  a_fail_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |->
      (m_axis_tdata == '0 && !m_axis_tuser[0] && !m_axis_tuser[1]))
    else $error("full-scale result carries data");

  // Ratio above the table forces zero temperature.
  a_above_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
    else $error("above-table result has nonzero temperature");
`endif

endmodule

// ===== verif/thermistor_adc_to_temperature_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for thermistor_adc_to_temperature_top: streams divider samples,
// predicts each temperature reading and its flags, and checks every result transfer.
// Depends on thermadc_pkg and the top-level RTL.
module thermistor_adc_to_temperature_top_tb;

  // Sample format and linearization constants, kept local to the bench
  localparam logic [11:0] SAMPLE_FULL   = 12'hFFF;   // converter failure code
  localparam logic [19:0] RATIO_CAP     = 20'd524288; // 8.0 in Q16
  localparam int          BAND_COUNT    = 10;
  localparam int          STEP_Q88      = 1280;       // 5.0 C per band
  localparam int          PIPE_LATENCY  = 40;
  localparam int          SETTLE_CYCLES = PIPE_LATENCY + 20;
  localparam int          WATCHDOG_MAX  = 4000;       // cycles with no transfer at all
  localparam int          REPORT_MAX    = 40;         // printed mismatch lines

  logic                                clk_i;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [thermadc_pkg::SAMPLE_W-1:0]   s_axis_tdata = '0;  // [11:0] adc_sample
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [thermadc_pkg::TEMP_W-1:0]     m_axis_tdata;       // [15:0] temperature
  logic [2:0]                          m_axis_tuser;       // [0] ok [1] above [2] full
  logic                                cfg_we_i = 1'b0;
  logic [thermadc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [thermadc_pkg::TEMP_W-1:0]     cfg_wdata_i = '0;

  thermistor_adc_to_temperature_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Bench copy of the limit registers, tracked on every write
  logic signed [15:0] limit_low  = 16'sd7680;
  logic signed [15:0] limit_high = 16'sd12800;

  thermadc_pkg::result_t pending_readings[$];  // oldest expected reading first

  int          error_count    = 0;
  int          samples_sent   = 0;
  int          readings_seen  = 0;
  int          limit_settings = 1;             // reset values count as one
  int          idle_cycles    = 0;
  bit          sender_gaps    = 1'b0;          // bursty sender when set
  int          burst_left     = 1;
  int          rx_mode        = 0;
  int          rx_cycle       = 0;
  int          rx_stall_left  = 0;

  // ------------------------------------------------------------------
  // Clock and reset
  // ------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // Temperature predictor
  // ------------------------------------------------------------------
  // Descending R/R25 band edges in Q16; entry i stands for (i-1)*5 C.
  function automatic logic [19:0] band_ratio(input int idx);
    case (idx)
      0:       return 20'd277348;
      1:       return 20'd213975;
      2:       return 20'd166396;
      3:       return 20'd130417;
      4:       return 20'd102957;
      5:       return 20'd81854;
      6:       return 20'd65536;
      7:       return 20'd52802;
      8:       return 20'd42802;
      default: return 20'd34911;
    endcase
  endfunction

  // s / (4095 - s) in Q16, rounded to nearest, saturated at 8.0
  function automatic logic [19:0] divider_ratio(input logic [11:0] sample);
    logic [63:0] span;
    logic [63:0] quot;
    span = 64'd4095 - 64'(sample);
    quot = ((64'(sample) << 16) + (span >> 1)) / span;
    if (quot > 64'(RATIO_CAP)) quot = 64'(RATIO_CAP);
    return quot[19:0];
  endfunction

  function automatic thermadc_pkg::result_t predict_reading(input logic [11:0] sample);
    thermadc_pkg::result_t res;
    logic [19:0] ratio;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] frac;
    int          band;
    int          seg;
    int          temp;
    res  = '0;
    temp = 0;
    if (sample == SAMPLE_FULL) begin
      res.adc_full_scale = 1'b1;        // failure: zero temp, never ok
      return res;
    end
    ratio = divider_ratio(sample);
    band  = -1;
    // highest index whose edge still covers the ratio
    for (int i = BAND_COUNT - 1; i >= 0; i--) begin
      if (band < 0 && band_ratio(i) >= ratio) band = i;
    end
    if (band < 0) begin
      res.ratio_above_table = 1'b1;
    end else begin
      // past the last edge the final segment is extrapolated
      seg  = (band > BAND_COUNT - 2) ? BAND_COUNT - 2 : band;
      num  = 64'(band_ratio(seg)) - 64'(ratio);
      den  = 64'(band_ratio(seg)) - 64'(band_ratio(seg + 1));
      frac = (64'(STEP_Q88) * num + (den >> 1)) / den;
      temp = (seg - 1) * STEP_Q88 + int'(frac);
      if (temp > 32767) temp = 32767;
      if (temp < -32768) temp = -32768;
    end
    res.temperature = temp[15:0];
    res.sensor_ok   = (temp >= int'(limit_low)) && (temp <= int'(limit_high));
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Result checking and receiver stalls
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int expected, input int got);
    if (error_count < REPORT_MAX)
      $display("[%0t] reading %0d: %s expected %0d got %0d",
               $realtime, readings_seen, what, expected, got);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    thermadc_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transfer, queue depth", 0, 1);
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata !== want.temperature)
          report_mismatch("temperature", int'($signed(want.temperature)),
                          int'($signed(m_axis_tdata)));
        if (m_axis_tuser[0] !== want.sensor_ok)
          report_mismatch("sensor_ok", int'(want.sensor_ok), int'(m_axis_tuser[0]));
        if (m_axis_tuser[1] !== want.ratio_above_table)
          report_mismatch("ratio_above_table", int'(want.ratio_above_table),
                          int'(m_axis_tuser[1]));
        if (m_axis_tuser[2] !== want.adc_full_scale)
          report_mismatch("adc_full_scale", int'(want.adc_full_scale),
                          int'(m_axis_tuser[2]));
      end
      readings_seen++;
    end

    // Receiver picks a new stall style at random, one of:
    // always ready, coin flip, one in four, or long stalls.
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_cycle % 4 == 0);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  // Watchdog: ends the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles, %0d readings outstanding",
                 idle_cycles, pending_readings.size());
        $display("thermistor_adc_to_temperature_top: mismatch");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  // One sample transfer; tvalid stays high into the next call unless a gap follows.
  task automatic send_sample(input logic [11:0] sample);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, sample};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(predict_reading(sample));
    samples_sent++;
    if (sender_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Wait until every reading is back and the pipeline has gone quiet
  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle; writes both registers back to back
  task automatic set_limits(input logic signed [15:0] low, input logic signed [15:0] high);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= thermadc_pkg::REG_LOW_LIMIT;
    cfg_wdata_i <= low;
    @(posedge clk_i);
    cfg_idx_i   <= thermadc_pkg::REG_HIGH_LIMIT;
    cfg_wdata_i <= high;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    limit_low  = low;
    limit_high = high;
    limit_settings++;
  endtask

  // Weighted toward the interpolated range (ratio inside the table),
  // with extrapolation, above-table, full-scale and raw bit patterns mixed in.
  function automatic logic [11:0] random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 12'($urandom_range(1400, 3320));
    if (pick < 75) return 12'($urandom_range(0, 1422));
    if (pick < 88) return 12'($urandom_range(3300, 4094));
    if (pick < 92) return SAMPLE_FULL;
    return 12'($urandom);
  endfunction

  // Last sample whose ratio still lies at or under band edge idx
  function automatic logic [11:0] last_sample_in_band(input int idx);
    logic [11:0] found;
    found = '0;
    for (int s = 0; s < 4095; s++) begin
      if (divider_ratio(12'(s)) <= band_ratio(idx)) found = 12'(s);
    end
    return found;
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Extremes plus both sides of every band edge, reset limits in force
  task automatic test_band_edges();
    logic [11:0] edge_sample;
    sender_gaps = 1'b0;
    send_sample(12'd0);          // ratio zero, extrapolated past the last edge
    send_sample(12'hAAA);
    send_sample(12'd3641);       // first sample where the ratio saturates at 8.0
    send_sample(12'd4094);       // largest valid sample, far above the table
    send_sample(SAMPLE_FULL);    // converter failure
    for (int i = 0; i < BAND_COUNT; i++) begin
      edge_sample = last_sample_in_band(i);
      send_sample(edge_sample);
      send_sample(edge_sample + 12'd1);
    end
    drain_readings();
  endtask

  // Limit extremes, inverted and zero-width windows, then random windows
  task automatic test_limit_settings();
    logic signed [15:0] lows [6];
    logic signed [15:0] highs[6];
    int a;
    int b;
    lows[0] = -16'sd32768; highs[0] = 16'sd32767;   // everything passes
    lows[1] = 16'sd32767;  highs[1] = -16'sd32768;  // nothing passes
    lows[2] = 16'sd0;      highs[2] = 16'sd0;       // only zero readings pass
    lows[3] = -16'sd1280;  highs[3] = 16'sd0;
    for (int k = 4; k < 6; k++) begin
      a = $urandom_range(0, 19000) - 2000;
      b = $urandom_range(0, 19000) - 2000;
      lows[k]  = 16'((a < b) ? a : b);
      highs[k] = 16'((a < b) ? b : a);
    end
    for (int k = 0; k < 6; k++) begin
      set_limits(lows[k], highs[k]);
      sender_gaps = (k % 2 == 1);
      repeat (45) send_sample(random_sample());
      drain_readings();
    end
  endtask

  // Long random stream in three chunks, each under fresh random limits
  task automatic test_random_samples();
    int a;
    int b;
    for (int chunk = 0; chunk < 3; chunk++) begin
      a = $urandom_range(0, 19000) - 2000;
      b = $urandom_range(0, 19000) - 2000;
      set_limits(16'((a < b) ? a : b), 16'((a < b) ? b : a));
      sender_gaps = (chunk != 1);   // middle chunk runs back to back
      repeat (160) send_sample(random_sample());
      drain_readings();
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_band_edges();
    test_limit_settings();
    test_random_samples();

    $display("run covered %0d samples and %0d readings under %0d limit settings",
             samples_sent, readings_seen, limit_settings);
    if (error_count == 0) begin
      $display("thermistor_adc_to_temperature_top: match");
    end else begin
      $display("%0d field mismatches", error_count);
      $display("thermistor_adc_to_temperature_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/thermadc_pkg.sv
rtl/thermistor_adc_to_temperature_top.sv
verif/thermistor_adc_to_temperature_top_tb.sv
